// ===== hw/rtl/idprs_pkg.sv =====
// shared types and constants for the int8 dot product round and saturate unit
package idprs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PROD_W  = 16;
    localparam int ACC_W   = 32;
    localparam int SHIFT_W = 6;
    localparam int OUT_W   = 8;
    localparam int WIDE_W  = ACC_W + 9;

    // symmetric accumulator and output limits
    localparam logic signed [ACC_W:0]    ACC_MAX = (ACC_W + 1)'(64'sd2147483647);
    localparam logic signed [ACC_W:0]    ACC_MIN = (ACC_W + 1)'(-64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'(127);
    localparam logic signed [WIDE_W-1:0] OUT_MIN = WIDE_W'(-127);
    localparam logic [SHIFT_W-1:0]       LSHIFT_CAP = SHIFT_W'(8);

    // one queued item: product already formed by the front end
    typedef struct packed {
        logic signed [PROD_W-1:0]  product;
        logic signed [SHIFT_W-1:0] shift;
        logic                      last;
    } entry_t;

    // status reported by the back end
    typedef struct packed {
        logic acc_zero;
        logic rnd_busy;
    } back_status_t;

endpackage

// ===== hw/rtl/idprs_front.sv =====
// front end: accepts items and forms the 8x8 product
module idprs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [7:0]    weight,
    input  logic signed [7:0]    activation,
    input  logic signed [5:0]    shift_amount,
    input  logic                 last_of_row,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 push_valid,
    input  logic                 push_ready,
    output idprs_pkg::entry_t    push_data
);
    import idprs_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

    always_comb
    begin
        entry_next.product = PROD_W'(weight) * PROD_W'(activation);
        entry_next.shift   = shift_amount;
        entry_next.last    = last_of_row;
        valid_next         = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== hw/rtl/idprs_queue.sv =====
// short fifo between front end and back end
module idprs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  idprs_pkg::entry_t    push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output idprs_pkg::entry_t    pop_data
);
    import idprs_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/idprs_back.sv =====
// back end: saturating accumulate, then rounding shift and output register
module idprs_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  idprs_pkg::entry_t        pop_data,
    output logic signed [7:0]        row_result,
    output logic                     out_valid,
    input  logic                     out_ready,
    output idprs_pkg::back_status_t  status
);
    import idprs_pkg::*;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W:0]     sum_wide;
    logic signed [ACC_W-1:0]   sum_sat;
    logic                      rnd_valid_reg;
    logic                      rnd_valid_next;
    logic signed [ACC_W-1:0]   rnd_sum_reg;
    logic signed [SHIFT_W-1:0] rnd_shift_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [OUT_W-1:0]   out_reg;
    logic                      out_free;
    logic                      rnd_free;
    logic                      do_pop;
    logic                      do_out;

    // rounding path
    logic [4:0]                rs;
    logic signed [ACC_W-1:0]   quo;
    logic [ACC_W-1:0]          mask;
    logic [ACC_W-1:0]          rem;
    logic [ACC_W-1:0]          half;
    logic                      round_up;
    logic [SHIFT_W-1:0]        lmag;
    logic [3:0]                lsh;
    logic signed [WIDE_W-1:0]  shifted;
    logic signed [OUT_W-1:0]   rounded;

    assign out_free   = !out_valid_reg || out_ready;
    assign rnd_free   = !rnd_valid_reg || out_free;
    assign pop_ready  = !pop_data.last || rnd_free;
    assign do_pop     = pop_valid && pop_ready;
    assign do_out     = rnd_valid_reg && out_free;
    assign row_result = out_reg;
    assign out_valid  = out_valid_reg;

    assign status.acc_zero = acc_reg == '0;
    assign status.rnd_busy = rnd_valid_reg;

    // accumulate with symmetric clamp
    always_comb
    begin
        sum_wide = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(pop_data.product);
        if (sum_wide > ACC_MAX)
        begin
            sum_sat = ACC_W'(ACC_MAX);
        end
        else if (sum_wide < ACC_MIN)
        begin
            sum_sat = ACC_W'(ACC_MIN);
        end
        else
        begin
            sum_sat = ACC_W'(sum_wide);
        end

        acc_next       = acc_reg;
        rnd_valid_next = rnd_valid_reg;
        if (do_out)
        begin
            rnd_valid_next = 1'b0;
        end
        if (do_pop)
        begin
            if (pop_data.last)
            begin
                acc_next       = '0;
                rnd_valid_next = 1'b1;
            end
            else
            begin
                acc_next = sum_sat;
            end
        end

        out_valid_next = out_valid_reg;
        if (do_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // shift with round half to even, or left shift, then clamp to int8
    always_comb
    begin
        rs       = rnd_shift_reg[4:0];
        quo      = rnd_sum_reg >>> rs;
        mask     = (ACC_W'(1) << rs) - ACC_W'(1);
        rem      = ACC_W'(rnd_sum_reg) & mask;
        half     = ACC_W'(1) << 5'(rs - 5'd1);
        round_up = (rem > half) || ((rem == half) && quo[0]);
        lmag     = SHIFT_W'(-rnd_shift_reg);
        lsh      = (lmag > LSHIFT_CAP) ? 4'(LSHIFT_CAP) : lmag[3:0];
        if (rnd_shift_reg > 0)
        begin
            shifted = WIDE_W'(quo) + WIDE_W'({1'b0, round_up});
        end
        else if (rnd_shift_reg < 0)
        begin
            shifted = WIDE_W'(rnd_sum_reg) <<< lsh;
        end
        else
        begin
            shifted = WIDE_W'(rnd_sum_reg);
        end
        if (shifted > OUT_MAX)
        begin
            rounded = OUT_W'(OUT_MAX);
        end
        else if (shifted < OUT_MIN)
        begin
            rounded = OUT_W'(OUT_MIN);
        end
        else
        begin
            rounded = OUT_W'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            rnd_valid_reg <= rnd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && pop_data.last)
        begin
            rnd_sum_reg   <= sum_sat;
            rnd_shift_reg <= pop_data.shift;
        end
        if (do_out)
        begin
            out_reg <= rounded;
        end
    end

endmodule

// ===== hw/rtl/int8_dot_product_round_sat_unit.sv =====
// top level of the int8 dot product unit with rounding shift and saturation
//
// input channel: one weight/activation pair per item, with the row's shift
// and a last_of_row flag, moved on in_valid & in_ready
// output channel: one int8 row_result per row, moved on out_valid & out_ready
// each product is added into a 32-bit sum clamped to +-(2^31-1); the item
// flagged last_of_row closes the row: the sum is shifted (right with round
// half to even, or left with saturation for a negative shift), clamped to
// -127..127 and sent, and the sum restarts from zero
// throughput: one item per cycle sustained while the rounding register can take
// each closed row, set by the accumulate loop in the back end
// the row's last item passes the front register, the queue, the rounding
// register and the output register before its row result is valid
// reset clears the sum and empties every stage; no result is pending
// when the receiver stalls, the output and rounding registers hold, the
// back end keeps accumulating items that are not last, and the four-entry
// queue fills before in_ready drops
module int8_dot_product_round_sat_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [7:0] weight,
    input  logic signed [7:0] activation,
    input  logic signed [5:0] shift_amount,
    input  logic              last_of_row,
    input  logic              in_valid,
    output logic              in_ready,
    output logic signed [7:0] row_result,
    output logic              out_valid,
    input  logic              out_ready
);
    import idprs_pkg::*;

    // front to queue
    logic         push_valid;
    logic         push_ready;
    entry_t       push_data;
    // queue to back
    logic         pop_valid;
    logic         pop_ready;
    entry_t       pop_data;
    back_status_t back_status;

    // accept and multiply
    idprs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .weight       (weight),
        .activation   (activation),
        .shift_amount (shift_amount),
        .last_of_row  (last_of_row),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // decouples the two sides so either can stall alone
    idprs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // accumulate, round and present the row result
    idprs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .row_result (row_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (back_status)
    );

    // the symmetric clamp never lets -128 out
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_result != -8'sd128)
        else $error("row result outside -127..127");

    // closing a row clears the running sum
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready && pop_data.last |=> back_status.acc_zero)
        else $error("sum not cleared after last item of row");

    // a closed row reaches the rounding stage in the next cycle
    a_row_to_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready && pop_data.last |=> back_status.rnd_busy)
        else $error("closed row did not reach rounding stage");

    // input stalls only when the front register cannot drain into the queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> push_valid && !push_ready)
        else $error("input stalled without a full queue");

endmodule
